FILE: rtl/core/c2r_pkg.sv
// Shared types and constants for the convolution-with-ReLU block.
`default_nettype none

package c2r_pkg;

   localparam int ACTION_W    = 2;
   localparam int PLANE_W     = 4;
   localparam int POS_FIELD_W = 6;
   localparam int VALUE_W     = 16;
   localparam int PROD_W      = 2 * VALUE_W;
   localparam int SUM_W       = 41;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 7;

   localparam int KSIZE_W  = 3;
   localparam int KCOUNT_W = 5;
   localparam int CCOUNT_W = 5;
   localparam int STRIDE_W = 3;
   localparam int PAD_W    = 2;
   localparam int ISIZE_W  = 7;

   localparam int MAX_STRIDE   = 4;
   localparam int DRAIN_CYCLES = 3;

   typedef enum logic [ACTION_W-1:0] {
      ACT_WEIGHT  = 2'd0,
      ACT_SAMPLE  = 2'd1,
      ACT_COMPUTE = 2'd2
   } c2r_action_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_KERNEL_SIDE   = 3'd0,
      CSR_KERNEL_COUNT  = 3'd1,
      CSR_CHANNEL_COUNT = 3'd2,
      CSR_STRIDE        = 3'd3,
      CSR_PADDING       = 3'd4,
      CSR_IMAGE_SIZE    = 3'd5
   } c2r_csr_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_DONE
   } c2r_state_type;

   typedef struct packed {
      logic [KSIZE_W-1:0]  kernel_side;
      logic [KCOUNT_W-1:0] kernel_count;
      logic [CCOUNT_W-1:0] channel_count;
      logic [STRIDE_W-1:0] stride;
      logic [PAD_W-1:0]    padding;
      logic [ISIZE_W-1:0]  image_size;
   } c2r_cfg_type;

   typedef struct packed {
      logic tap_valid;
      logic tap_ok;
      logic acc_clear;
   } c2r_ctl_type;

endpackage

`default_nettype wire

FILE: rtl/core/c2r_store.sv
// Weight and image sample memories with load write port and registered tap read.
`default_nettype none

module c2r_store #(
   parameter int MAX_KERNEL_SIDE = 7,
   parameter int MAX_KERNELS     = 16,
   parameter int MAX_CHANNELS    = 16,
   parameter int MAX_IMAGE_SIDE  = 64,
   parameter int WA_W            = 10,
   parameter int IA_W            = 16
) (
   input  wire logic                                clock,
   input  wire logic                                load_accept,
   input  wire logic [c2r_pkg::ACTION_W-1:0]        req_action,
   input  wire logic [c2r_pkg::PLANE_W-1:0]         req_plane,
   input  wire logic [c2r_pkg::POS_FIELD_W-1:0]     req_row,
   input  wire logic [c2r_pkg::POS_FIELD_W-1:0]     req_col,
   input  wire logic signed [c2r_pkg::VALUE_W-1:0]  req_value,
   input  wire logic [WA_W-1:0]                     wgt_rd_addr,
   input  wire logic [IA_W-1:0]                     img_rd_addr,
   output logic signed [c2r_pkg::VALUE_W-1:0]       wgt_rd_data,
   output logic signed [c2r_pkg::VALUE_W-1:0]       img_rd_data
);
   import c2r_pkg::*;

   localparam int WGT_DEPTH = MAX_KERNELS * MAX_KERNEL_SIDE * MAX_KERNEL_SIDE;
   localparam int IMG_DEPTH = MAX_CHANNELS * MAX_IMAGE_SIDE * MAX_IMAGE_SIDE;

   logic [VALUE_W-1:0] wgt_mem [WGT_DEPTH];
   logic [VALUE_W-1:0] img_mem [IMG_DEPTH];

   logic            wgt_we;
   logic            img_we;
   logic [WA_W-1:0] wgt_wr_addr;
   logic [IA_W-1:0] img_wr_addr;

   always_comb begin
      wgt_we = load_accept && (req_action == ACT_WEIGHT)
               && (32'(req_plane) < MAX_KERNELS)
               && (32'(req_row) < MAX_KERNEL_SIDE)
               && (32'(req_col) < MAX_KERNEL_SIDE);
      img_we = load_accept && (req_action == ACT_SAMPLE)
               && (32'(req_plane) < MAX_CHANNELS)
               && (32'(req_row) < MAX_IMAGE_SIDE)
               && (32'(req_col) < MAX_IMAGE_SIDE);
      wgt_wr_addr = WA_W'(req_plane) * WA_W'(MAX_KERNEL_SIDE * MAX_KERNEL_SIDE)
                    + WA_W'(req_row) * WA_W'(MAX_KERNEL_SIDE) + WA_W'(req_col);
      img_wr_addr = IA_W'(req_plane) * IA_W'(MAX_IMAGE_SIDE * MAX_IMAGE_SIDE)
                    + IA_W'(req_row) * IA_W'(MAX_IMAGE_SIDE) + IA_W'(req_col);
   end

   always_ff @(posedge clock) begin
      if (wgt_we) begin
         wgt_mem[wgt_wr_addr] <= req_value;
      end
      wgt_rd_data <= wgt_mem[wgt_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (img_we) begin
         img_mem[img_wr_addr] <= req_value;
      end
      img_rd_data <= img_mem[img_rd_addr];
   end

endmodule

`default_nettype wire

FILE: rtl/core/c2r_mac.sv
// Shared multiply-accumulate unit with ReLU on the finished sum.
`default_nettype none

module c2r_mac #(
   parameter int MAX_KERNEL_SIDE = 7,
   parameter int MAX_CHANNELS    = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire c2r_pkg::c2r_ctl_type                ctl,
   input  wire logic signed [c2r_pkg::VALUE_W-1:0]  sample,
   input  wire logic signed [c2r_pkg::VALUE_W-1:0]  weight,
   output logic [c2r_pkg::SUM_W-1:0]                relu_sum
);
   import c2r_pkg::*;

   localparam int ACC_W = PROD_W + $clog2(MAX_CHANNELS * MAX_KERNEL_SIDE * MAX_KERNEL_SIDE + 1) + 1;

   logic                     rd_ok_ff;
   logic                     rd_ok_in;
   logic                     prod_ok_ff;
   logic                     prod_ok_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;

   always_comb begin
      rd_ok_in   = ctl.tap_valid && ctl.tap_ok;
      prod_ok_in = rd_ok_ff;
      prod_in    = sample * weight;
      priority if (ctl.acc_clear) begin
         acc_in = '0;
      end else if (prod_ok_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end else begin
         acc_in = acc_ff;
      end
      relu_sum = acc_ff[ACC_W-1] ? '0 : SUM_W'($unsigned(acc_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ok_ff   <= 1'b0;
         prod_ok_ff <= 1'b0;
      end else begin
         rd_ok_ff   <= rd_ok_in;
         prod_ok_ff <= prod_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

endmodule

`default_nettype wire

FILE: rtl/core/c2r_seq.sv
// Sequencer: range check, channel and tap counters, tap address generation.
`default_nettype none

module c2r_seq #(
   parameter int MAX_KERNEL_SIDE = 7,
   parameter int MAX_KERNELS     = 16,
   parameter int MAX_CHANNELS    = 16,
   parameter int MAX_IMAGE_SIDE  = 64,
   parameter int WA_W            = 10,
   parameter int IA_W            = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire logic [c2r_pkg::PLANE_W-1:0]      req_plane,
   input  wire logic [c2r_pkg::POS_FIELD_W-1:0]  req_row,
   input  wire logic [c2r_pkg::POS_FIELD_W-1:0]  req_col,
   input  wire c2r_pkg::c2r_cfg_type             cfg,
   output logic                                  busy,
   output c2r_pkg::c2r_ctl_type                  ctl,
   output logic [WA_W-1:0]                       wgt_addr,
   output logic [IA_W-1:0]                       img_addr,
   output logic                                  rsp_strobe,
   output logic [c2r_pkg::PLANE_W-1:0]           rsp_out_plane,
   output logic [c2r_pkg::POS_FIELD_W-1:0]       rsp_out_row,
   output logic [c2r_pkg::POS_FIELD_W-1:0]       rsp_out_col,
   output logic                                  rsp_status
);
   import c2r_pkg::*;

   localparam int KS_W  = $clog2(MAX_KERNEL_SIDE + 1);
   localparam int K_W   = (MAX_KERNEL_SIDE > 1) ? $clog2(MAX_KERNEL_SIDE) : 1;
   localparam int KC_W  = $clog2(MAX_KERNELS + 1);
   localparam int CC_W  = $clog2(MAX_CHANNELS + 1);
   localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int IS_W  = $clog2(MAX_IMAGE_SIDE + 1);
   localparam int IX_W  = $clog2(MAX_IMAGE_SIDE);
   localparam int ST_W  = $clog2(MAX_STRIDE + 1);
   localparam int DR_W  = $clog2(DRAIN_CYCLES);
   localparam int POS_W = $clog2(((1 << POS_FIELD_W) - 1) * MAX_STRIDE + MAX_IMAGE_SIDE
                                 + 2 * MAX_KERNEL_SIDE) + 2;

   c2r_state_type state_ff, state_in;

   logic [PLANE_W-1:0]     plane_ff, plane_in;
   logic [POS_FIELD_W-1:0] row_ff, row_in;
   logic [POS_FIELD_W-1:0] col_ff, col_in;
   logic                   status_ff, status_in;
   logic [KS_W-1:0]        ks_ff, ks_in;
   logic [CC_W-1:0]        cc_ff, cc_in;
   logic [IS_W-1:0]        is_ff, is_in;
   logic signed [POS_W-1:0] base_x_ff, base_x_in;
   logic signed [POS_W-1:0] base_y_ff, base_y_in;
   logic [CH_W-1:0]        ch_ff, ch_in;
   logic [K_W-1:0]         k_ff, k_in;
   logic [K_W-1:0]         l_ff, l_in;
   logic [DR_W-1:0]        drain_ff, drain_in;
   logic [WA_W-1:0]        wgt_addr_ff, wgt_addr_in;
   logic [IA_W-1:0]        img_addr_ff, img_addr_in;
   logic                   tap_valid_ff, tap_valid_in;
   logic                   tap_ok_ff, tap_ok_in;

   logic [KS_W-1:0]         ks_c;
   logic [KC_W-1:0]         kc_c;
   logic [CC_W-1:0]         cc_c;
   logic [ST_W-1:0]         st_c;
   logic [IS_W-1:0]         is_c;
   logic signed [POS_W-1:0] span_c;
   logic signed [POS_W-1:0] row_sc;
   logic signed [POS_W-1:0] col_sc;
   logic                    in_range;
   logic signed [POS_W-1:0] x_c;
   logic signed [POS_W-1:0] y_c;
   logic                    tap_ok_c;
   logic                    l_last;
   logic                    k_last;
   logic                    ch_last;
   logic                    tap_last;
   logic                    drain_last;

   // clamp the live registers and check the requested position
   always_comb begin
      if (cfg.kernel_side == '0) begin
         ks_c = KS_W'(1);
      end else if (32'(cfg.kernel_side) > MAX_KERNEL_SIDE) begin
         ks_c = KS_W'(MAX_KERNEL_SIDE);
      end else begin
         ks_c = KS_W'(cfg.kernel_side);
      end
      if (cfg.kernel_count == '0) begin
         kc_c = KC_W'(1);
      end else if (32'(cfg.kernel_count) > MAX_KERNELS) begin
         kc_c = KC_W'(MAX_KERNELS);
      end else begin
         kc_c = KC_W'(cfg.kernel_count);
      end
      if (cfg.channel_count == '0) begin
         cc_c = CC_W'(1);
      end else if (32'(cfg.channel_count) > MAX_CHANNELS) begin
         cc_c = CC_W'(MAX_CHANNELS);
      end else begin
         cc_c = CC_W'(cfg.channel_count);
      end
      if (cfg.stride == '0) begin
         st_c = ST_W'(1);
      end else if (32'(cfg.stride) > MAX_STRIDE) begin
         st_c = ST_W'(MAX_STRIDE);
      end else begin
         st_c = ST_W'(cfg.stride);
      end
      if (cfg.image_size == '0) begin
         is_c = IS_W'(1);
      end else if (32'(cfg.image_size) > MAX_IMAGE_SIDE) begin
         is_c = IS_W'(MAX_IMAGE_SIDE);
      end else begin
         is_c = IS_W'(cfg.image_size);
      end
      span_c   = POS_W'(is_c) + (POS_W'(cfg.padding) << 1) - POS_W'(ks_c);
      row_sc   = POS_W'(req_row) * POS_W'(st_c);
      col_sc   = POS_W'(req_col) * POS_W'(st_c);
      in_range = (32'(req_plane) < 32'(kc_c)) && !span_c[POS_W-1]
                 && (row_sc <= span_c) && (col_sc <= span_c);
   end

   // current tap
   always_comb begin
      x_c        = base_x_ff + POS_W'(k_ff);
      y_c        = base_y_ff + POS_W'(l_ff);
      tap_ok_c   = !x_c[POS_W-1] && (x_c < $signed(POS_W'(is_ff)))
                   && !y_c[POS_W-1] && (y_c < $signed(POS_W'(is_ff)));
      l_last     = (32'(l_ff) + 1) == 32'(ks_ff);
      k_last     = (32'(k_ff) + 1) == 32'(ks_ff);
      ch_last    = (32'(ch_ff) + 1) == 32'(cc_ff);
      tap_last   = l_last && k_last && ch_last;
      drain_last = 32'(drain_ff) == (DRAIN_CYCLES - 1);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = in_range ? ST_RUN : ST_DONE;
            end
         end
         ST_RUN: begin
            if (tap_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (drain_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath registers
   always_comb begin
      plane_in     = plane_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      status_in    = status_ff;
      ks_in        = ks_ff;
      cc_in        = cc_ff;
      is_in        = is_ff;
      base_x_in    = base_x_ff;
      base_y_in    = base_y_ff;
      ch_in        = ch_ff;
      k_in         = k_ff;
      l_in         = l_ff;
      drain_in     = drain_ff;
      tap_valid_in = (state_ff == ST_RUN);
      tap_ok_in    = tap_ok_c;
      wgt_addr_in  = WA_W'(plane_ff) * WA_W'(MAX_KERNEL_SIDE * MAX_KERNEL_SIDE)
                     + WA_W'(k_ff) * WA_W'(MAX_KERNEL_SIDE) + WA_W'(l_ff);
      if (tap_ok_c) begin
         img_addr_in = IA_W'(ch_ff) * IA_W'(MAX_IMAGE_SIDE * MAX_IMAGE_SIDE)
                       + IA_W'(x_c[IX_W-1:0]) * IA_W'(MAX_IMAGE_SIDE)
                       + IA_W'(y_c[IX_W-1:0]);
      end else begin
         img_addr_in = '0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               plane_in  = req_plane;
               row_in    = req_row;
               col_in    = req_col;
               status_in = !in_range;
               ks_in     = ks_c;
               cc_in     = cc_c;
               is_in     = is_c;
               base_x_in = row_sc - POS_W'(cfg.padding);
               base_y_in = col_sc - POS_W'(cfg.padding);
               ch_in     = '0;
               k_in      = '0;
               l_in      = '0;
               drain_in  = '0;
            end
         end
         ST_RUN: begin
            if (l_last) begin
               l_in = '0;
               if (k_last) begin
                  k_in  = '0;
                  ch_in = ch_ff + CH_W'(1);
               end else begin
                  k_in = k_ff + K_W'(1);
               end
            end else begin
               l_in = l_ff + K_W'(1);
            end
         end
         ST_DRAIN: begin
            drain_in = drain_ff + DR_W'(1);
         end
         default: begin
         end
      endcase
   end

   // outputs
   always_comb begin
      busy          = (state_ff != ST_IDLE);
      rsp_strobe    = (state_ff == ST_DONE);
      ctl.tap_valid = tap_valid_ff;
      ctl.tap_ok    = tap_ok_ff;
      ctl.acc_clear = (state_ff == ST_IDLE);
      wgt_addr      = wgt_addr_ff;
      img_addr      = img_addr_ff;
      rsp_out_plane = plane_ff;
      rsp_out_row   = row_ff;
      rsp_out_col   = col_ff;
      rsp_status    = status_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tap_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tap_valid_ff <= tap_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      plane_ff    <= plane_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      status_ff   <= status_in;
      ks_ff       <= ks_in;
      cc_ff       <= cc_in;
      is_ff       <= is_in;
      base_x_ff   <= base_x_in;
      base_y_ff   <= base_y_in;
      ch_ff       <= ch_in;
      k_ff        <= k_in;
      l_ff        <= l_in;
      drain_ff    <= drain_in;
      tap_ok_ff   <= tap_ok_in;
      wgt_addr_ff <= wgt_addr_in;
      img_addr_ff <= img_addr_in;
   end

   a_run_counters_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> ((32'(l_ff) < 32'(ks_ff)) && (32'(k_ff) < 32'(ks_ff))
                                && (32'(ch_ff) < 32'(cc_ff))))
      else $error("tap counter beyond kernel or channel count");

   a_tap_only_in_run: assert property (@(posedge clock) disable iff (reset)
      tap_valid_ff |-> ($past(state_ff) == ST_RUN))
      else $error("tap issued outside run state");

   a_bad_position_skips_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> !status_ff)
      else $error("out of range request entered the tap loop");

endmodule

`default_nettype wire

FILE: rtl/core/conv2d_relu_forward.sv
// Top level of the multichannel 2D convolution with ReLU, one output per compute request.
// Usage:
//   Request channel: a word is taken when req_start is high and busy is low.
//   req_action selects weight load, image sample load or compute. Loads are
//   written at the accepting edge and leave busy low, so loads may follow
//   each other every cycle. A compute raises busy until its result is out.
//   Result channel: rsp_strobe marks a single cycle holding rsp_sum, the
//   echoed plane/row/col and rsp_status. There is no backpressure.
//   Config channel: csr_ready is always high; write only while idle.
// Compute sequence:
//   A compute in range steps through N = channel_count * kernel_size^2
//   taps, one tap per cycle, through the single shared multiply-accumulate,
//   then drains the pipeline (memory read, product, accumulate) before
//   the strobe. A position or plane out of range answers with status 1
//   in the cycle after the accept. Busy drops the cycle after the strobe,
//   so a new word is taken only once the previous compute has finished.
// Reset: config, state and valid flags return to their defaults; datapath
//   registers and memory contents are undefined until written and need no clearing.
`default_nettype none

module conv2d_relu_forward #(
   parameter int MAX_KERNEL_SIDE = 7,
   parameter int MAX_KERNELS     = 16,
   parameter int MAX_CHANNELS    = 16,
   parameter int MAX_IMAGE_SIDE  = 64
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_start,
   output logic                                     busy,
   input  wire logic [c2r_pkg::ACTION_W-1:0]        req_action,
   input  wire logic [c2r_pkg::PLANE_W-1:0]         req_plane,
   input  wire logic [c2r_pkg::POS_FIELD_W-1:0]     req_row,
   input  wire logic [c2r_pkg::POS_FIELD_W-1:0]     req_col,
   input  wire logic signed [c2r_pkg::VALUE_W-1:0]  req_value,
   output logic                                     rsp_strobe,
   output logic [c2r_pkg::SUM_W-1:0]                rsp_sum,
   output logic [c2r_pkg::PLANE_W-1:0]              rsp_out_plane,
   output logic [c2r_pkg::POS_FIELD_W-1:0]          rsp_out_row,
   output logic [c2r_pkg::POS_FIELD_W-1:0]          rsp_out_col,
   output logic                                     rsp_status,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [c2r_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [c2r_pkg::CSR_DATA_W-1:0]      csr_data
);
   import c2r_pkg::*;

   localparam int WGT_DEPTH = MAX_KERNELS * MAX_KERNEL_SIDE * MAX_KERNEL_SIDE;
   localparam int IMG_DEPTH = MAX_CHANNELS * MAX_IMAGE_SIDE * MAX_IMAGE_SIDE;
   localparam int WA_W      = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1;
   localparam int IA_W      = (IMG_DEPTH > 1) ? $clog2(IMG_DEPTH) : 1;

   c2r_cfg_type cfg_ff, cfg_in;
   c2r_ctl_type ctl;

   logic                       req_accept;
   logic                       compute_start;
   logic [WA_W-1:0]            wgt_addr;
   logic [IA_W-1:0]            img_addr;
   logic signed [VALUE_W-1:0]  wgt_rd_data;
   logic signed [VALUE_W-1:0]  img_rd_data;
   logic [SUM_W-1:0]           relu_sum;

   always_comb begin
      csr_ready     = 1'b1;
      req_accept    = req_start && !busy;
      compute_start = req_accept && (req_action == ACT_COMPUTE);
      cfg_in        = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_KERNEL_SIDE:   cfg_in.kernel_side   = csr_data[KSIZE_W-1:0];
            CSR_KERNEL_COUNT:  cfg_in.kernel_count  = csr_data[KCOUNT_W-1:0];
            CSR_CHANNEL_COUNT: cfg_in.channel_count = csr_data[CCOUNT_W-1:0];
            CSR_STRIDE:        cfg_in.stride        = csr_data[STRIDE_W-1:0];
            CSR_PADDING:       cfg_in.padding       = csr_data[PAD_W-1:0];
            CSR_IMAGE_SIZE:    cfg_in.image_size    = csr_data[ISIZE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{kernel_side:   KSIZE_W'(3),
                     kernel_count:  KCOUNT_W'(1),
                     channel_count: CCOUNT_W'(1),
                     stride:        STRIDE_W'(1),
                     padding:       PAD_W'(0),
                     image_size:    ISIZE_W'(28)};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   c2r_seq #(
      .MAX_KERNEL_SIDE (MAX_KERNEL_SIDE),
      .MAX_KERNELS     (MAX_KERNELS),
      .MAX_CHANNELS    (MAX_CHANNELS),
      .MAX_IMAGE_SIDE  (MAX_IMAGE_SIDE),
      .WA_W            (WA_W),
      .IA_W            (IA_W)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .start         (compute_start),
      .req_plane     (req_plane),
      .req_row       (req_row),
      .req_col       (req_col),
      .cfg           (cfg_ff),
      .busy          (busy),
      .ctl           (ctl),
      .wgt_addr      (wgt_addr),
      .img_addr      (img_addr),
      .rsp_strobe    (rsp_strobe),
      .rsp_out_plane (rsp_out_plane),
      .rsp_out_row   (rsp_out_row),
      .rsp_out_col   (rsp_out_col),
      .rsp_status    (rsp_status)
   );

   c2r_store #(
      .MAX_KERNEL_SIDE (MAX_KERNEL_SIDE),
      .MAX_KERNELS     (MAX_KERNELS),
      .MAX_CHANNELS    (MAX_CHANNELS),
      .MAX_IMAGE_SIDE  (MAX_IMAGE_SIDE),
      .WA_W            (WA_W),
      .IA_W            (IA_W)
   ) u_store (
      .clock       (clock),
      .load_accept (req_accept),
      .req_action  (req_action),
      .req_plane   (req_plane),
      .req_row     (req_row),
      .req_col     (req_col),
      .req_value   (req_value),
      .wgt_rd_addr (wgt_addr),
      .img_rd_addr (img_addr),
      .wgt_rd_data (wgt_rd_data),
      .img_rd_data (img_rd_data)
   );

   c2r_mac #(
      .MAX_KERNEL_SIDE (MAX_KERNEL_SIDE),
      .MAX_CHANNELS    (MAX_CHANNELS)
   ) u_mac (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .sample   (img_rd_data),
      .weight   (wgt_rd_data),
      .relu_sum (relu_sum)
   );

   assign rsp_sum = relu_sum;

   a_strobe_then_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !busy)
      else $error("block still busy after result word");

   a_error_sum_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status) |-> (rsp_sum == '0))
      else $error("error status with nonzero sum");

   a_compute_goes_busy: assert property (@(posedge clock) disable iff (reset)
      compute_start |=> busy)
      else $error("compute word accepted without going busy");

   a_load_stays_idle: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_action != ACT_COMPUTE)) |=> !busy && !rsp_strobe)
      else $error("load word caused busy or a result");

endmodule

`default_nettype wire

FILE: dv/conv_pixel_check.sv
// Watches the request, result and register channels, predicts each output pixel and compares.
module conv_pixel_check #(
   parameter int MAX_KERNEL_SIDE = 7,
   parameter int MAX_KERNELS     = 16,
   parameter int MAX_CHANNELS    = 16,
   parameter int MAX_IMAGE_SIDE  = 64
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_start,
   input  logic                                    busy,
   input  logic [c2r_pkg::ACTION_W-1:0]            req_action,
   input  logic [c2r_pkg::PLANE_W-1:0]             req_plane,
   input  logic [c2r_pkg::POS_FIELD_W-1:0]         req_row,
   input  logic [c2r_pkg::POS_FIELD_W-1:0]         req_col,
   input  logic [c2r_pkg::VALUE_W-1:0]             req_value,
   input  logic                                    rsp_strobe,
   input  logic [c2r_pkg::SUM_W-1:0]               rsp_sum,
   input  logic [c2r_pkg::PLANE_W-1:0]             rsp_out_plane,
   input  logic [c2r_pkg::POS_FIELD_W-1:0]         rsp_out_row,
   input  logic [c2r_pkg::POS_FIELD_W-1:0]         rsp_out_col,
   input  logic                                    rsp_status,
   input  logic                                    csr_valid,
   input  logic                                    csr_ready,
   input  logic [c2r_pkg::CSR_INDEX_W-1:0]         csr_index,
   input  logic [c2r_pkg::CSR_DATA_W-1:0]          csr_data,
   output int                                      pending,
   output int                                      failures
);
   timeunit 1ns;
   timeprecision 1ps;

   import c2r_pkg::*;

   localparam int WEIGHT_DEPTH = MAX_KERNELS * MAX_KERNEL_SIDE * MAX_KERNEL_SIDE;
   localparam int SAMPLE_DEPTH = MAX_CHANNELS * MAX_IMAGE_SIDE * MAX_IMAGE_SIDE;

   typedef struct packed {
      logic [SUM_W-1:0]       sum;
      logic [PLANE_W-1:0]     plane;
      logic [POS_FIELD_W-1:0] row;
      logic [POS_FIELD_W-1:0] col;
      logic                   status;
   } pixel_type;

   logic [VALUE_W-1:0] weight_mem [WEIGHT_DEPTH];
   logic [VALUE_W-1:0] sample_mem [SAMPLE_DEPTH];
   c2r_cfg_type        layer;
   pixel_type          expected_pixels [$];
   int                 fail_count = 0;

   initial begin
      pending  = 0;
      failures = 0;
   end

   function automatic int clamp_to(input int v, input int hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic pixel_type convolve_pixel(input logic [PLANE_W-1:0] plane,
                                                input logic [POS_FIELD_W-1:0] row,
                                                input logic [POS_FIELD_W-1:0] col);
      int        ks, kc, cc, st, pd, side, span, out_side, x, y, ch, k, l;
      longint    acc;
      pixel_type px;
      ks = clamp_to(int'(layer.kernel_side), MAX_KERNEL_SIDE);
      kc = clamp_to(int'(layer.kernel_count), MAX_KERNELS);
      cc = clamp_to(int'(layer.channel_count), MAX_CHANNELS);
      st = clamp_to(int'(layer.stride), MAX_STRIDE);
      pd = int'(layer.padding);
      side = clamp_to(int'(layer.image_size), MAX_IMAGE_SIDE);
      span = side + 2 * pd - ks;
      out_side = (span < 0) ? 0 : span / st + 1;
      px.sum = '0;
      px.plane = plane;
      px.row = row;
      px.col = col;
      px.status = 1'b0;
      if (int'(plane) >= kc || int'(row) >= out_side || int'(col) >= out_side) begin
         px.status = 1'b1;
         return px;
      end
      acc = 0;
      for (ch = 0; ch < cc; ch++) begin
         for (k = 0; k < ks; k++) begin
            x = int'(row) * st - pd + k;
            if (x >= 0 && x < side) begin
               for (l = 0; l < ks; l++) begin
                  y = int'(col) * st - pd + l;
                  if (y >= 0 && y < side) begin
                     acc += longint'($signed(sample_mem[(ch * MAX_IMAGE_SIDE + x)
                                                        * MAX_IMAGE_SIDE + y]))
                          * longint'($signed(weight_mem[(int'(plane) * MAX_KERNEL_SIDE + k)
                                                        * MAX_KERNEL_SIDE + l]));
                  end
               end
            end
         end
      end
      if (acc > 0) px.sum = acc[SUM_W-1:0];
      return px;
   endfunction

   task automatic check_field(input string name, input longint unsigned want,
                              input longint unsigned got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      pixel_type want;
      if (reset) begin
         layer.kernel_side   = 3'd3;
         layer.kernel_count  = 5'd1;
         layer.channel_count = 5'd1;
         layer.stride        = 3'd1;
         layer.padding       = 2'd0;
         layer.image_size    = 7'd28;
         expected_pixels.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_KERNEL_SIDE:   layer.kernel_side   = csr_data[KSIZE_W-1:0];
               CSR_KERNEL_COUNT:  layer.kernel_count  = csr_data[KCOUNT_W-1:0];
               CSR_CHANNEL_COUNT: layer.channel_count = csr_data[CCOUNT_W-1:0];
               CSR_STRIDE:        layer.stride        = csr_data[STRIDE_W-1:0];
               CSR_PADDING:       layer.padding       = csr_data[PAD_W-1:0];
               CSR_IMAGE_SIZE:    layer.image_size    = csr_data[ISIZE_W-1:0];
               default: ;
            endcase
         end
         if (rsp_strobe) begin
            if (expected_pixels.size() == 0) begin
               $error("result word with none expected: plane %0d row %0d col %0d sum %0d",
                      rsp_out_plane, rsp_out_row, rsp_out_col, rsp_sum);
               fail_count++;
            end else begin
               want = expected_pixels.pop_front();
               check_field("sum", want.sum, rsp_sum);
               check_field("out_plane", want.plane, rsp_out_plane);
               check_field("out_row", want.row, rsp_out_row);
               check_field("out_col", want.col, rsp_out_col);
               check_field("status", want.status, rsp_status);
            end
         end
         if (req_start && !busy) begin
            case (req_action)
               ACT_WEIGHT: begin
                  if (req_plane < MAX_KERNELS && req_row < MAX_KERNEL_SIDE
                      && req_col < MAX_KERNEL_SIDE)
                     weight_mem[(int'(req_plane) * MAX_KERNEL_SIDE + int'(req_row))
                                * MAX_KERNEL_SIDE + int'(req_col)] = req_value;
               end
               ACT_SAMPLE: begin
                  if (req_plane < MAX_CHANNELS && req_row < MAX_IMAGE_SIDE
                      && req_col < MAX_IMAGE_SIDE)
                     sample_mem[(int'(req_plane) * MAX_IMAGE_SIDE + int'(req_row))
                                * MAX_IMAGE_SIDE + int'(req_col)] = req_value;
               end
               ACT_COMPUTE: expected_pixels.push_back(convolve_pixel(req_plane, req_row, req_col));
               default: ;
            endcase
         end
      end
      pending  <= expected_pixels.size();
      failures <= fail_count;
   end

endmodule

FILE: dv/testbench.sv
// Top of the convolution testbench: clock, reset, stimulus and the final verdict.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import c2r_pkg::*;

   localparam int KSIDE = 7;
   localparam int KNUM  = 16;
   localparam int CHNUM = 16;
   localparam int ISIDE = 64;

   localparam int RANDOM_ITEMS  = 1150;
   localparam int CYCLE_LIMIT   = 5000000;
   localparam int SETTLE_CYCLES = DRAIN_CYCLES + 8;

   localparam logic [ACTION_W-1:0]    ACT_UNUSED   = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HI = 3'd7;

   localparam int VALUE_MIN = -32768;
   localparam int VALUE_MAX = 32767;

   logic                          clock         = 1'b0;
   logic                          reset         = 1'b1;
   logic                          req_start     = 1'b0;
   logic [ACTION_W-1:0]           req_action    = '0;
   logic [PLANE_W-1:0]            req_plane     = '0;
   logic [POS_FIELD_W-1:0]        req_row       = '0;
   logic [POS_FIELD_W-1:0]        req_col       = '0;
   logic signed [VALUE_W-1:0]     req_value     = '0;
   logic                          csr_valid     = 1'b0;
   logic [CSR_INDEX_W-1:0]        csr_index     = '0;
   logic [CSR_DATA_W-1:0]         csr_data      = '0;
   logic                          busy;
   logic                          rsp_strobe;
   logic [SUM_W-1:0]              rsp_sum;
   logic [PLANE_W-1:0]            rsp_out_plane;
   logic [POS_FIELD_W-1:0]        rsp_out_row;
   logic [POS_FIELD_W-1:0]        rsp_out_col;
   logic                          rsp_status;
   logic                          csr_ready;
   int                            pending_pixels;
   int                            fail_total;

   // layer setup as written, and what the block makes of it
   int layer_ks = 3, layer_kc = 1, layer_cc = 1, layer_st = 1, layer_pd = 0, layer_is = 28;
   int eff_ks, eff_kc, eff_cc, eff_st, eff_pd, eff_is, out_side;

   bit weight_loaded [KNUM * KSIDE * KSIDE];
   bit sample_loaded [CHNUM * ISIDE * ISIDE];
   int words_taken = 0;
   bit no_idle = 1'b0;
   int cycle_count = 0;

   always #5ns clock = ~clock;

   conv2d_relu_forward #(
      .MAX_KERNEL_SIDE(KSIDE),
      .MAX_KERNELS(KNUM),
      .MAX_CHANNELS(CHNUM),
      .MAX_IMAGE_SIDE(ISIDE)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_start(req_start),
      .busy(busy),
      .req_action(req_action),
      .req_plane(req_plane),
      .req_row(req_row),
      .req_col(req_col),
      .req_value(req_value),
      .rsp_strobe(rsp_strobe),
      .rsp_sum(rsp_sum),
      .rsp_out_plane(rsp_out_plane),
      .rsp_out_row(rsp_out_row),
      .rsp_out_col(rsp_out_col),
      .rsp_status(rsp_status),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   conv_pixel_check #(
      .MAX_KERNEL_SIDE(KSIDE),
      .MAX_KERNELS(KNUM),
      .MAX_CHANNELS(CHNUM),
      .MAX_IMAGE_SIDE(ISIDE)
   ) i_pixel_check (
      .clock(clock),
      .reset(reset),
      .req_start(req_start),
      .busy(busy),
      .req_action(req_action),
      .req_plane(req_plane),
      .req_row(req_row),
      .req_col(req_col),
      .req_value(req_value),
      .rsp_strobe(rsp_strobe),
      .rsp_sum(rsp_sum),
      .rsp_out_plane(rsp_out_plane),
      .rsp_out_row(rsp_out_row),
      .rsp_out_col(rsp_out_col),
      .rsp_status(rsp_status),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .pending(pending_pixels),
      .failures(fail_total)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic int fit_range(input int v, input int hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int pick_value();
      case ($urandom_range(0, 9))
         0: return VALUE_MIN;
         1: return VALUE_MAX;
         2: return 0;
         default: return $urandom;
      endcase
   endfunction

   task automatic update_layout();
      int span;
      eff_ks = fit_range(layer_ks, KSIDE);
      eff_kc = fit_range(layer_kc, KNUM);
      eff_cc = fit_range(layer_cc, CHNUM);
      eff_st = fit_range(layer_st, MAX_STRIDE);
      eff_pd = layer_pd;
      eff_is = fit_range(layer_is, ISIDE);
      span = eff_is + 2 * eff_pd - eff_ks;
      out_side = (span < 0) ? 0 : span / eff_st + 1;
   endtask

   task automatic send_word(input logic [ACTION_W-1:0] action, input int plane, input int row,
                            input int col, input int value);
      logic [PLANE_W-1:0]     p;
      logic [POS_FIELD_W-1:0] r;
      logic [POS_FIELD_W-1:0] c;
      int                     gap;
      p = PLANE_W'(plane);
      r = POS_FIELD_W'(row);
      c = POS_FIELD_W'(col);
      req_action <= action;
      req_plane  <= p;
      req_row    <= r;
      req_col    <= c;
      req_value  <= VALUE_W'(value);
      req_start  <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (action == ACT_WEIGHT && r < KSIDE && c < KSIDE) begin
         weight_loaded[(int'(p) * KSIDE + int'(r)) * KSIDE + int'(c)] = 1'b1;
      end else if (action == ACT_SAMPLE) begin
         sample_loaded[(int'(p) * ISIDE + int'(r)) * ISIDE + int'(c)] = 1'b1;
      end
      words_taken++;
      gap = pick_gap();
      if (gap > 0) begin
         req_start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_start <= 1'b0;
      do @(posedge clock); while (pending_pixels != 0 || busy);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_reg(input logic [CSR_INDEX_W-1:0] index, input int field, input int width);
      logic [CSR_DATA_W-1:0] mask;
      logic [CSR_DATA_W-1:0] data;
      mask = CSR_DATA_W'((1 << width) - 1);
      data = (CSR_DATA_W'($urandom) & ~mask) | (CSR_DATA_W'(field) & mask);
      csr_index <= index;
      csr_data  <= data;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // upper data bits beyond each field are random, so truncation gets exercised
   task automatic configure(input int ks, input int kc, input int cc, input int st,
                            input int pd, input int is);
      set_reg(CSR_KERNEL_SIDE, ks, KSIZE_W);
      set_reg(CSR_KERNEL_COUNT, kc, KCOUNT_W);
      set_reg(CSR_CHANNEL_COUNT, cc, CCOUNT_W);
      set_reg(CSR_STRIDE, st, STRIDE_W);
      set_reg(CSR_PADDING, pd, PAD_W);
      set_reg(CSR_IMAGE_SIZE, is, ISIZE_W);
      if ($urandom_range(0, 2) == 0)
         set_reg($urandom_range(0, 1) ? CSR_SPARE_HI : CSR_SPARE_LO, $urandom, CSR_DATA_W);
      csr_valid <= 1'b0;
      layer_ks = ks & ((1 << KSIZE_W) - 1);
      layer_kc = kc & ((1 << KCOUNT_W) - 1);
      layer_cc = cc & ((1 << CCOUNT_W) - 1);
      layer_st = st & ((1 << STRIDE_W) - 1);
      layer_pd = pd & ((1 << PAD_W) - 1);
      layer_is = is & ((1 << ISIZE_W) - 1);
      update_layout();
   endtask

   // fills every tap the window will read that was never loaded, then requests the pixel
   task automatic run_pixel(input int plane, input int row, input int col);
      int ch, k, l, x, y;
      if (plane < eff_kc && row < out_side && col < out_side) begin
         for (ch = 0; ch < eff_cc; ch++) begin
            for (k = 0; k < eff_ks; k++) begin
               x = row * eff_st - eff_pd + k;
               if (x >= 0 && x < eff_is) begin
                  for (l = 0; l < eff_ks; l++) begin
                     y = col * eff_st - eff_pd + l;
                     if (y >= 0 && y < eff_is) begin
                        if (!sample_loaded[(ch * ISIDE + x) * ISIDE + y])
                           send_word(ACT_SAMPLE, ch, x, y, pick_value());
                        if (!weight_loaded[(plane * KSIDE + k) * KSIDE + l])
                           send_word(ACT_WEIGHT, plane, k, l, pick_value());
                     end
                  end
               end
            end
         end
      end
      send_word(ACT_COMPUTE, plane, row, col, $urandom);
   endtask

   task automatic random_word();
      int r, lim, row, col;
      r = $urandom_range(0, 99);
      if (r < 45) begin
         if (out_side > 0 && $urandom_range(0, 9) < 8) begin
            lim = (out_side > ISIDE) ? ISIDE : out_side;
            run_pixel($urandom_range(0, eff_kc - 1), $urandom_range(0, lim - 1),
                      $urandom_range(0, lim - 1));
         end else begin
            run_pixel($urandom_range(0, KNUM - 1), $urandom_range(0, ISIDE - 1),
                      $urandom_range(0, ISIDE - 1));
         end
      end else if (r < 70) begin
         if ($urandom_range(0, 1))
            send_word(ACT_SAMPLE, $urandom_range(0, eff_cc - 1), $urandom_range(0, eff_is - 1),
                      $urandom_range(0, eff_is - 1), pick_value());
         else
            send_word(ACT_SAMPLE, $urandom, $urandom, $urandom, $urandom);
      end else if (r < 85) begin
         send_word(ACT_WEIGHT, $urandom, $urandom_range(0, KSIDE - 1),
                   $urandom_range(0, KSIDE - 1), pick_value());
      end else if (r < 93) begin
         row = $urandom_range(KSIDE, ISIDE - 1);
         col = $urandom_range(0, ISIDE - 1);
         if ($urandom_range(0, 1))
            send_word(ACT_WEIGHT, $urandom, row, col, $urandom);
         else
            send_word(ACT_WEIGHT, $urandom, col, row, $urandom);
      end else begin
         send_word(ACT_UNUSED, $urandom, $urandom, $urandom, $urandom);
      end
   endtask

   initial begin : stimulus
      int k, l, phase, budget, phase_start, run_start;
      update_layout();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // default layer: 3x3 kernel, one channel, 28x28 image
      for (k = 0; k < 3; k++)
         for (l = 0; l < 3; l++)
            send_word(ACT_WEIGHT, 0, k, l, VALUE_MIN);
      for (k = 0; k < 3; k++)
         for (l = 0; l < 3; l++)
            send_word(ACT_SAMPLE, 0, k, l, VALUE_MIN);
      send_word(ACT_COMPUTE, 0, 0, 0, 0);
      send_word(ACT_WEIGHT, 15, 7, 6, 1);
      send_word(ACT_UNUSED, 15, 63, 63, -1);
      send_word(ACT_SAMPLE, 15, 63, 63, VALUE_MAX);
      send_word(ACT_COMPUTE, 15, 0, 0, 0);
      send_word(ACT_COMPUTE, 0, out_side, 0, 0);
      send_word(ACT_COMPUTE, 0, 0, 63, 0);
      send_word(ACT_SAMPLE, 0, 1, 1, VALUE_MAX);
      send_word(ACT_COMPUTE, 0, 0, 0, 0);

      run_start = words_taken;
      phase = 0;
      while (words_taken - run_start < RANDOM_ITEMS) begin
         wait_idle();
         case (phase)
            0: configure(7, 31, 2, 7, 3, 127);
            1: configure(0, 0, 0, 0, 0, 0);
            2: configure(7, 1, 1, 1, 0, 1);
            3: configure(1, 16, 31, 4, 3, 64);
            4: configure(5, 2, 2, 2, 3, 3);
            5: configure(2, 3, 16, 1, 1, 5);
            default: begin
               configure(($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(0, 7),
                         ($urandom_range(0, 9) < 7) ? $urandom_range(1, 4) : $urandom_range(0, 31),
                         ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(0, 31),
                         ($urandom_range(0, 9) < 7) ? $urandom_range(1, 2) : $urandom_range(0, 7),
                         $urandom_range(0, 3),
                         ($urandom_range(0, 3) < 3) ? $urandom_range(1, 10) : $urandom_range(0, 127));
            end
         endcase
         no_idle = ($urandom_range(0, 3) == 0);
         budget = $urandom_range(30, 100);
         phase_start = words_taken;
         while (words_taken - phase_start < budget && words_taken - run_start < RANDOM_ITEMS)
            random_word();
         phase++;
      end

      wait_idle();
      if (fail_total == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
